[rtl/core/bdrm_pkg.sv]
`timescale 1ns / 1ps

package bdrm_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;
  localparam int unsigned FuncW  = 2;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_REMOVE     = 2'd2,
    FUNC_READ_ALL   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_READ
  } state_e;

endpackage

[rtl/core/bdrm_ram.sv]
`timescale 1ns / 1ps

module bdrm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bounded_deque_remove_matching_unit.sv]
`timescale 1ns / 1ps

// Bounded deque of signed 32-bit entries kept in a circular buffer in one
// RAM with a registered read. A push never raises busy, so pushes can be
// issued on every cycle. A remove-all-matching request walks the stored
// entries through the single RAM read port, one per cycle, and compacts the
// survivors in place; busy is high while it runs, even on an empty list. A
// read-all request streams the entries front to back, one per cycle, while
// busy is high; on an empty list it answers at once and busy stays low. Each
// result is shown for one cycle with valid_o high, in the cycle after the
// work that made it; the receiver cannot stall, so results must be captured
// when valid_o is high.
module bounded_deque_remove_matching_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  bdrm_pkg::func_e                     func_i,
  input  logic signed [bdrm_pkg::DataW-1:0]   value_i,
  output logic                                valid_o,
  output logic                                ok_o,
  output logic [bdrm_pkg::CountW-1:0]         removed_count_o,
  output logic signed [bdrm_pkg::DataW-1:0]   item_o,
  output logic                                empty_res_o,
  output logic                                last_o
);

  import bdrm_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam logic [AW:0]   CapW = (AW+1)'(CAPACITY);
  localparam logic [LW-1:0] CapL = LW'(CAPACITY);
  localparam logic [AW-1:0] LastSlot = AW'(CAPACITY - 1);

  state_e state_q, state_d;

  logic [AW-1:0]    head_q, head_d;
  logic [LW-1:0]    len_q, len_d;
  logic [LW-1:0]    idx_q, idx_d;
  logic [LW-1:0]    keep_q, keep_d;
  logic [LW-1:0]    cnt_q, cnt_d;
  logic [DataW-1:0] value_q, value_d;
  logic             rd_valid_q, rd_valid_d;
  logic             rd_last_q, rd_last_d;

  logic             valid_q, valid_d;
  logic             ok_q, ok_d;
  logic [CountW-1:0] rcnt_q, rcnt_d;
  logic [DataW-1:0] item_q, item_d;
  logic             empty_q, empty_d;
  logic             last_q, last_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  logic [AW-1:0]    wadd_op;
  logic [AW:0]      rsum, wsum;
  logic [AW-1:0]    raddr_wrap, waddr_wrap;

  // A push at the back writes just past the last entry; a remove writes the
  // next kept slot.
  assign wadd_op = (state_q == ST_IDLE) ? len_q[AW-1:0] : keep_q[AW-1:0];

  // Physical slot of a logical position: head plus offset, wrapped once.
  always_comb begin
    rsum = {1'b0, head_q} + {1'b0, idx_q[AW-1:0]};
    if (rsum >= CapW) begin
      rsum = rsum - CapW;
    end
    raddr_wrap = rsum[AW-1:0];
    wsum = {1'b0, head_q} + {1'b0, wadd_op};
    if (wsum >= CapW) begin
      wsum = wsum - CapW;
    end
    waddr_wrap = wsum[AW-1:0];
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    len_d      = len_q;
    idx_d      = idx_q;
    keep_d     = keep_q;
    cnt_d      = cnt_q;
    value_d    = value_q;
    rd_valid_d = 1'b0;
    rd_last_d  = 1'b0;
    valid_d    = 1'b0;
    ok_d       = 1'b0;
    rcnt_d     = '0;
    item_d     = '0;
    empty_d    = 1'b0;
    last_d     = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = raddr_wrap;
    ram_waddr  = waddr_wrap;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (func_i)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
              valid_d = 1'b1;
              last_d  = 1'b1;
              if (len_q != CapL) begin
                ok_d      = 1'b1;
                len_d     = len_q + LW'(1);
                ram_we    = 1'b1;
                ram_wdata = value_i;
                if (func_i == FUNC_PUSH_FRONT) begin
                  head_d    = (head_q == '0) ? LastSlot : head_q - AW'(1);
                  ram_waddr = head_d;
                end
              end
            end
            FUNC_REMOVE: begin
              state_d = ST_REMOVE;
              idx_d   = '0;
              keep_d  = '0;
              cnt_d   = '0;
              value_d = value_i;
            end
            FUNC_READ_ALL: begin
              if (len_q == '0) begin
                valid_d = 1'b1;
                empty_d = 1'b1;
                last_d  = 1'b1;
              end else begin
                state_d = ST_READ;
                idx_d   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_REMOVE: begin
        if (idx_q < len_q) begin
          ram_re     = 1'b1;
          idx_d      = idx_q + LW'(1);
          rd_valid_d = 1'b1;
        end
        // Entries that do not match slide down to the next kept slot.
        if (rd_valid_q) begin
          if (ram_rdata == value_q) begin
            cnt_d = cnt_q + LW'(1);
          end else begin
            ram_we = 1'b1;
            keep_d = keep_q + LW'(1);
          end
        end
        if (!(idx_q < len_q) && !rd_valid_q) begin
          len_d   = keep_q;
          valid_d = 1'b1;
          rcnt_d  = CountW'(cnt_q);
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_READ: begin
        if (idx_q < len_q) begin
          ram_re     = 1'b1;
          idx_d      = idx_q + LW'(1);
          rd_valid_d = 1'b1;
          rd_last_d  = ((idx_q + LW'(1)) == len_q);
        end
        if (rd_valid_q) begin
          valid_d = 1'b1;
          item_d  = ram_rdata;
          last_d  = rd_last_q;
          if (rd_last_q) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      len_q      <= '0;
      idx_q      <= '0;
      keep_q     <= '0;
      cnt_q      <= '0;
      rd_valid_q <= 1'b0;
      rd_last_q  <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      len_q      <= len_d;
      idx_q      <= idx_d;
      keep_q     <= keep_d;
      cnt_q      <= cnt_d;
      rd_valid_q <= rd_valid_d;
      rd_last_q  <= rd_last_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    ok_q    <= ok_d;
    rcnt_q  <= rcnt_d;
    item_q  <= item_d;
    empty_q <= empty_d;
    last_q  <= last_d;
  end

  bdrm_ram #(
    .Width(DataW),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy            = (state_q != ST_IDLE);
  assign valid_o         = valid_q;
  assign ok_o            = ok_q;
  assign removed_count_o = rcnt_q;
  assign item_o          = item_q;
  assign empty_res_o     = empty_q;
  assign last_o          = last_q;

endmodule
